[sv/fixed_point_alu_assert.svh]
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// implication checked on every clock edge outside reset
`define FPA_ASSERT_IMP(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FPA_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

[sv/fpa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
    localparam int FRACTION_BITS = 8;
    localparam int W = 32;
    // dividend width: sign-extended a shifted up by the fraction bits
    localparam int DW = W + FRACTION_BITS + 1;
    // one cell per quotient bit
    localparam int NCELLS = DW;
    // cycles from start to strobe: input stage, divider row, output stage
    localparam int LATENCY = NCELLS + 2;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
        OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
    } t_op;

    typedef struct packed {
        logic [3:0]          op;
        logic signed [W-1:0] operand_a;
        logic signed [W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] result;
        logic                compare_true;
        logic                divide_by_zero;
    } t_out;

    // beat travelling along the cell row
    typedef struct packed {
        logic          valid;
        logic          is_div;
        logic          neg_q;
        logic          dz;
        logic [W-1:0]  res;      // result of non-divide ops
        logic          cmp;
        logic [DW-1:0] rem;      // partial remainder
        logic [DW-1:0] quo;      // dividend bits shifting out, quotient shifting in
        logic [W-1:0]  dvs;      // divisor magnitude
    } t_beat;
endpackage
`default_nettype wire

[sv/fpa_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_cell import fpa_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_beat i_beat,
    output t_beat      o_beat
);
    t_beat         r_beat;
    t_beat         n_beat;
    logic [DW-1:0] trial;
    logic [DW:0]   diff;

    // one restoring division step
    always_comb begin
        n_beat = i_beat;
        trial  = {i_beat.rem[DW-2:0], i_beat.quo[DW-1]};
        diff   = {1'b0, trial} - {{(DW-W+1){1'b0}}, i_beat.dvs};
        if (!diff[DW]) begin
            n_beat.rem = diff[DW-1:0];
            n_beat.quo = {i_beat.quo[DW-2:0], 1'b1};
        end else begin
            n_beat.rem = trial;
            n_beat.quo = {i_beat.quo[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;
endmodule
`default_nettype wire

[sv/fpa_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module fpa_front import fpa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_in  i_in,
    output t_beat     o_beat
);
    t_beat                 r_beat;
    t_beat                 n_beat;
    logic signed [W-1:0]   a;
    logic signed [W-1:0]   b;
    logic signed [2*W-1:0] prod;
    logic signed [DW-1:0]  dvd;
    logic [DW-1:0]         dvd_mag;
    logic [W-1:0]          one;
    logic                  lt;

    // non-divide ops and compares, divide operand preparation
    always_comb begin
        a       = i_in.operand_a;
        b       = i_in.operand_b;
        one     = W'(1) << FRACTION_BITS;
        prod    = (2*W)'(a) * (2*W)'(b);
        dvd     = DW'(a) <<< FRACTION_BITS;
        dvd_mag = dvd[DW-1] ? DW'(-dvd) : dvd;
        lt      = a < b;
        n_beat        = '0;
        n_beat.valid  = i_valid;
        n_beat.quo    = dvd_mag;
        n_beat.dvs    = b[W-1] ? W'(-b) : W'(b);
        n_beat.neg_q  = a[W-1] ^ b[W-1];
        case (t_op'(i_in.op))
            OP_ADD:      n_beat.res = W'(a + b);
            OP_SUB:      n_beat.res = W'(a - b);
            OP_MUL:      n_beat.res = prod[FRACTION_BITS +: W];
            OP_DIV: begin
                n_beat.is_div = (b != 0);
                n_beat.dz     = (b == 0);
            end
            OP_GT:       n_beat.cmp = a > b;
            OP_LT:       n_beat.cmp = lt;
            OP_GE:       n_beat.cmp = !lt;
            OP_LE:       n_beat.cmp = a <= b;
            OP_EQ:       n_beat.cmp = a == b;
            OP_NE:       n_beat.cmp = a != b;
            OP_MIN:      n_beat.res = lt ? a : b;
            OP_MAX:      n_beat.res = (a > b) ? a : b;
            OP_INC:      n_beat.res = W'(a) + one;
            OP_DEC:      n_beat.res = W'(a) - one;
            OP_FROM_INT: n_beat.res = W'(a) << FRACTION_BITS;
            default:     n_beat.res = W'(a >>> FRACTION_BITS);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;
endmodule
`default_nettype wire

[sv/fixed_point_alu.sv]
// fixed-point alu, q format with FRACTION_BITS fraction bits
// a beat passes the operand stage, the row of NCELLS divider cells and the output register to o_strobe
// throughput: one operation per cycle, set by the row of one-bit divider cells
// busy is always low; the receiver cannot stall, every result is a one-cycle strobe
// reset (synchronous, active low) clears all valid flags; no results appear until new starts
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_alu_assert.svh"
module fixed_point_alu import fpa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_in  i_in,
    output logic      busy,
    output logic      o_strobe,
    output t_out      o_out
);
    t_beat          row [NCELLS+1];
    t_out           r_out;
    t_out           n_out;
    logic           r_strobe;
    logic [DW-1:0]  q;

    assign busy = 1'b0;

    // operand stage
    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_in    (i_in),
        .o_beat  (row[0])
    );

    // divider row, one quotient bit per cell
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        fpa_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (row[g]),
            .o_beat  (row[g+1])
        );
    end

    // result select and sign fix
    always_comb begin
        q = row[NCELLS].neg_q ? DW'(-row[NCELLS].quo) : row[NCELLS].quo;
        n_out.result         = row[NCELLS].is_div ? q[W-1:0] : row[NCELLS].res;
        n_out.compare_true   = row[NCELLS].cmp;
        n_out.divide_by_zero = row[NCELLS].dz;
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= row[NCELLS].valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    `FPA_ASSERT_IMP(a_dz_clean, i_clk, i_rst_n, o_strobe && o_out.divide_by_zero,
        o_out.result == 0 && !o_out.compare_true, "divide by zero result not clean")
    `FPA_ASSERT_IMP(a_cmp_zero, i_clk, i_rst_n, o_strobe && o_out.compare_true,
        o_out.result == 0 && !o_out.divide_by_zero, "comparison result not zero")
    `FPA_ASSERT_NEXT(a_tail, i_clk, i_rst_n, row[NCELLS].valid, o_strobe,
        "lost beat at output")
endmodule
`default_nettype wire

[tb/sv/fixed_point_alu_test.sv]
`timescale 1ns / 1ps
module fixed_point_alu_test;
    import fpa_pkg::*;

    // keeps the expected results in issue order and compares each strobe against them
    class alu_scoreboard;
        t_out pending[$];
        int   mismatches;
        int   checked;

        // expected result for one accepted operation
        function t_out predict(t_in x);
            t_out r;
            logic signed [63:0] a, b, p, n;
            logic signed [31:0] one;
            a = x.operand_a;
            b = x.operand_b;
            one = 32'sd1 <<< FRACTION_BITS;
            r = '0;
            case (t_op'(x.op))
                OP_ADD: r.result = 32'(a + b);
                OP_SUB: r.result = 32'(a - b);
                OP_MUL: begin
                    p = a * b;
                    r.result = 32'(p >>> FRACTION_BITS);
                end
                OP_DIV: begin
                    if (b == 0) begin
                        r.divide_by_zero = 1'b1;
                    end else begin
                        n = a <<< FRACTION_BITS;
                        r.result = 32'(n / b);
                    end
                end
                OP_GT: r.compare_true = a > b;
                OP_LT: r.compare_true = a < b;
                OP_GE: r.compare_true = a >= b;
                OP_LE: r.compare_true = a <= b;
                OP_EQ: r.compare_true = a == b;
                OP_NE: r.compare_true = a != b;
                OP_MIN: r.result = (a < b) ? 32'(a) : 32'(b);
                OP_MAX: r.result = (a > b) ? 32'(a) : 32'(b);
                OP_INC: r.result = 32'(a + one);
                OP_DEC: r.result = 32'(a - one);
                OP_FROM_INT: r.result = 32'(a <<< FRACTION_BITS);
                default: r.result = 32'(a >>> FRACTION_BITS);
            endcase
            return r;
        endfunction

        function void note_op(t_in x);
            pending.push_back(predict(x));
        endfunction

        function void check_result(t_out got);
            t_out want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want res %h cmp %b dz %b, got res %h cmp %b dz %b",
                             want.result, want.compare_true, want.divide_by_zero,
                             got.result, got.compare_true, got.divide_by_zero);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_in  i_in = '0;
    logic busy;
    logic o_strobe;
    t_out o_out;

    alu_scoreboard sb = new();
    int n_ops;
    int n_div;

    fixed_point_alu uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_in(i_in),
        .busy(busy), .o_strobe(o_strobe), .o_out(o_out)
    );

    always #4 i_clk = ~i_clk;

    // capture every result strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_out);
    end

    // mostly short idle gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // operand with a bias towards edge values and small numbers
    function logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'(int'($urandom_range(0, 4095)) - 2048);
            4: return 32'(int'($urandom_range(0, 255)) - 128) << FRACTION_BITS;
            5: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // hold one beat until accepted, then idle for gap cycles
    task automatic send_op(t_op op, logic [31:0] a, logic [31:0] b, int gap);
        i_in.op <= op;
        i_in.operand_a <= a;
        i_in.operand_b <= b;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_op(i_in);
        n_ops++;
        if (op == OP_DIV) n_div++;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin
        int waited;
        t_op op;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every operation at the extremes, divide by zero, min/max ties
        for (int k = 0; k < 16; k++)
            send_op(t_op'(k), 32'h8000_0000, 32'h7fff_ffff, 0);
        send_op(OP_DIV, 32'h0000_0300, 32'h0000_0000, 0);
        send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1);
        send_op(OP_DIV, 32'hffff_fd00, 32'h0000_0200, 0);
        send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
        send_op(OP_MUL, 32'hffff_ffff, 32'h0000_0001, 0);
        send_op(OP_MIN, 32'h0000_0100, 32'h0000_0100, 0);
        send_op(OP_MAX, 32'hffff_ffff, 32'hffff_ffff, 0);
        send_op(OP_TO_INT, 32'hffff_ff01, 32'h0, 2);
        send_op(OP_INC, 32'h7fff_ff80, 32'hffff_ffff, 0);

        // random part, a random idle gap after each beat
        for (int k = 0; k < 1650; k++) begin
            op = t_op'($urandom_range(0, 15));
            send_op(op, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'h0 : pick_operand(),
                    pick_gap());
        end
        start <= 1'b0;

        // drain
        waited = 0;
        while (sb.pending.size() != 0 && waited < 20 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d operations (%0d divides), %0d results checked",
                 n_ops, n_div, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule

[files.f]
+incdir+sv
sv/fpa_pkg.sv
sv/fpa_div_cell.sv
sv/fpa_front.sv
sv/fixed_point_alu.sv
tb/sv/fixed_point_alu_test.sv
